[rtl/core/trajectory_segment_classifier_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory segment classifier checker
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_SEGMENT_CLASSIFIER_CORE_DEFINES_SVH
`define TRAJECTORY_SEGMENT_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define TSC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tsc: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define TSC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tsc: next-cycle check failed");

// Next-cycle implication that also covers the reset cycles.
`define TSC_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("tsc: reset check failed");

`endif

[rtl/core/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and fixed constants of the trajectory segment classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

    localparam int TIME_W   = 62;
    localparam int RANGE_W  = 24;
    localparam int SPEED_W  = 16;
    localparam int MINDUR_W = 40;
    localparam int CLASS_W  = 3;

    // segment results that can wait between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CLASS_W-1:0] {
        CLS_UNKNOWN    = 3'd0,
        CLS_PASS_BY    = 3'd1,
        CLS_STATIONARY = 3'd2,
        CLS_APPROACH   = 3'd3,
        CLS_RECEDE     = 3'd4
    } t_seg_class;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

[rtl/core/tsc_if.sv]
// ----------------------------------------------------------------------------
// tsc_in_if / tsc_out_if
// Valid/ready channels for sample beats and class beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
    import tsc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         sample_time;
    logic                      sample_valid;
    logic [RANGE_W-1:0]        range_value;
    logic signed [SPEED_W-1:0] closing_speed;
    logic                      last_sample;

    modport source (
        output valid, sample_time, sample_valid, range_value, closing_speed, last_sample,
        input  ready
    );
    modport sink (
        input  valid, sample_time, sample_valid, range_value, closing_speed, last_sample,
        output ready
    );
endinterface

interface tsc_out_if;
    import tsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] segment_class;

    modport source (output valid, segment_class, input ready);
    modport sink (input valid, segment_class, output ready);
endinterface

`default_nettype wire

[rtl/core/tsc_front.sv]
// ----------------------------------------------------------------------------
// tsc_front
// Accepts sample beats, keeps running segment statistics, pushes a snapshot
// of them into the queue on the last sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_front #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tsc_in_if.sink                             i_in,
    input  wire logic                          i_cfg_we,
    input  wire logic [tsc_pkg::MINDUR_W-1:0]  i_cfg_wdata,
    input  wire tsc_pkg::t_q_status            i_q_stat,
    output logic                               o_push,
    output logic [$clog2(MAX_SAMPLES+1)*2+16+2*tsc_pkg::RANGE_W
                  +((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1):0] o_entry
);
    import tsc_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW = CW + SPEED_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

    logic                  r_seen;
    logic [TIME_W-1:0]     r_start;
    logic [CW-1:0]         r_cnt;
    logic [RANGE_W-1:0]    r_lo;
    logic [RANGE_W-1:0]    r_hi;
    logic [PW-1:0]         r_pos;
    logic signed [SW-1:0]  r_sum;
    logic [MINDUR_W-1:0]   r_min_dur;

    logic [CW-1:0]         n_cnt;
    logic [RANGE_W-1:0]    n_lo;
    logic [RANGE_W-1:0]    n_hi;
    logic [PW-1:0]         n_pos;
    logic signed [SW-1:0]  n_sum;

    logic                  acc;
    logic                  take;
    logic                  first;
    logic [TIME_W-1:0]     start_eff;
    logic [TIME_W:0]       diff;
    logic                  dur_ok;

    assign i_in.ready = !i_q_stat.full;
    assign acc        = i_in.valid && i_in.ready;
    assign o_push     = acc && i_in.last_sample;

    always_comb begin
        take  = i_in.sample_valid && (r_cnt < CNT_MAX);
        first = (r_cnt == '0);
        n_cnt = r_cnt;
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_pos = r_pos;
        n_sum = r_sum;
        if (take) begin
            if (first || (i_in.range_value < r_lo)) begin
                n_lo  = i_in.range_value;
                n_pos = r_cnt[PW-1:0];
            end
            if (first || (i_in.range_value > r_hi)) begin
                n_hi = i_in.range_value;
            end
            n_sum = r_sum + SW'(i_in.closing_speed);
            n_cnt = r_cnt + 1'b1;
        end
        // time going backwards shows as a borrow out of the subtract
        start_eff = r_seen ? r_start : i_in.sample_time;
        diff      = {1'b0, i_in.sample_time} - {1'b0, start_eff};
        dur_ok    = !diff[TIME_W] &&
                    (diff[TIME_W-1:0] >= {{(TIME_W-MINDUR_W){1'b0}}, r_min_dur});
    end

    assign o_entry = {dur_ok, n_cnt, n_sum, n_lo, n_hi, n_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dur <= '0;
        end else if (i_cfg_we) begin
            r_min_dur <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_start <= '0;
            r_cnt   <= '0;
            r_lo    <= '1;
            r_hi    <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
        end else if (acc) begin
            if (i_in.last_sample) begin
                r_seen  <= 1'b0;
                r_start <= '0;
                r_cnt   <= '0;
                r_lo    <= '1;
                r_hi    <= '0;
                r_pos   <= '0;
                r_sum   <= '0;
            end else begin
                r_seen  <= 1'b1;
                r_start <= start_eff;
                r_cnt   <= n_cnt;
                r_lo    <= n_lo;
                r_hi    <= n_hi;
                r_pos   <= n_pos;
                r_sum   <= n_sum;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/tsc_queue.sv]
// ----------------------------------------------------------------------------
// tsc_queue
// Short FIFO of segment snapshots between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_queue #(
    parameter int W = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [W-1:0]       i_data,
    input  wire logic               i_pop,
    output logic [W-1:0]            o_data,
    output tsc_pkg::t_q_status      o_stat
);
    import tsc_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [AW:0] FULL_CNT = (AW + 1)'(QUEUE_DEPTH);

    logic [W-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/tsc_back.sv]
// ----------------------------------------------------------------------------
// tsc_back
// Evaluates the class thresholds of a segment snapshot (stage 1) and holds
// the resulting class in the output register (stage 2).
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_back #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tsc_pkg::t_q_status            i_q_stat,
    input  wire logic [$clog2(MAX_SAMPLES+1)*2+16+2*tsc_pkg::RANGE_W
                       +((MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1):0] i_entry,
    output logic                               o_pop,
    tsc_out_if.source                          o_out
);
    import tsc_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW = CW + SPEED_W;
    localparam int MW = CW + 4;
    localparam int XW = SW + 10;

    typedef struct packed {
        logic unk;
        logic pass;
        logic stat;
        logic appr;
        logic rece;
    } t_cls_flags;

    logic                  e_dur_ok;
    logic [CW-1:0]         e_cnt;
    logic signed [SW-1:0]  e_sum;
    logic [RANGE_W-1:0]    e_lo;
    logic [RANGE_W-1:0]    e_hi;
    logic [PW-1:0]         e_pos;

    logic [RANGE_W-1:0]    d;
    logic [30:0]           d100;
    logic [30:0]           hi15;
    logic [27:0]           d10;
    logic [MW-1:0]         p5;
    logic [MW-1:0]         p5_1;
    logic [MW-1:0]         n4;
    logic signed [XW-1:0]  s_x;
    logic signed [XW-1:0]  n256;
    logic signed [XW-1:0]  n128;
    t_cls_flags            f;

    logic                  r_s1_v;
    t_cls_flags            r_f;
    logic                  r_out_v;
    t_seg_class            r_cls;
    t_seg_class            n_cls;
    logic                  adv1;
    logic                  adv2;

    assign {e_dur_ok, e_cnt, e_sum, e_lo, e_hi, e_pos} = i_entry;

    // Divisions of the thresholds are rewritten as cross-multiplications:
    // p > n/5 is n < 5p, p+1 <= 4n/5 is 5(p+1) <= 4n.
    always_comb begin
        d    = e_hi - e_lo;
        d100 = 31'(d) * 31'd100;
        hi15 = 31'(e_hi) * 31'd15;
        d10  = 28'(d) * 28'd10;
        p5   = MW'(e_pos) * MW'(5);
        p5_1 = p5 + MW'(5);
        n4   = MW'(e_cnt) << 2;
        s_x  = XW'(e_sum);
        n256 = $signed(XW'({e_cnt, 8'd0}));
        n128 = $signed(XW'({e_cnt, 7'd0}));

        f.unk  = (e_cnt == '0) || !e_dur_ok;
        f.pass = (e_hi != '0) && (d100 > hi15) && (MW'(e_cnt) < p5) && (p5_1 <= n4);
        f.stat = ((e_hi == '0) || (d10 < 28'(e_hi))) && (s_x < n256) && (s_x > -n256);
        f.appr = (s_x > n128);
        f.rece = (s_x < -n128);
    end

    always_comb begin
        if (r_f.unk) begin
            n_cls = CLS_UNKNOWN;
        end else if (r_f.pass) begin
            n_cls = CLS_PASS_BY;
        end else if (r_f.stat) begin
            n_cls = CLS_STATIONARY;
        end else if (r_f.appr) begin
            n_cls = CLS_APPROACH;
        end else if (r_f.rece) begin
            n_cls = CLS_RECEDE;
        end else begin
            n_cls = CLS_UNKNOWN;
        end
    end

    assign adv2  = !r_out_v || o_out.ready;
    assign adv1  = !r_s1_v || adv2;
    assign o_pop = !i_q_stat.empty && adv1;

    assign o_out.valid         = r_out_v;
    assign o_out.segment_class = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= !i_q_stat.empty;
            end
            if (adv2) begin
                r_out_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_f <= f;
        end
        if (adv2) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

[rtl/core/trajectory_segment_classifier_core.sv]
// ----------------------------------------------------------------------------
// trajectory_segment_classifier_core
// Classifies a segment of geometry samples into one of five classes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : sample beats (time, valid flag, range, closing speed, last mark).
//           One beat per cycle is taken while i_in.ready is high; a beat without last_sample yields
//           no result, a beat with last_sample yields one class beat on o_out.
//   o_out : class beats, 0 unknown, 1 pass_by, 2 stationary, 3 approach,
//           4 recede.
//   i_cfg_we / i_cfg_wdata : writes min_duration_ns; write it only while no
//           segment is in flight.
//   Path: a last-sample beat is written into the queue, then its flags
//           into the threshold stage register, then its class into the
//           output register that drives o_out.
//   Throughput: one sample beat per cycle while i_in.ready is high, also
//           across segment boundaries; the running statistics update once per beat.
//   Stall: while o_out is held, up to two finished segments wait in the
//           queue and one in the threshold stage; i_in.ready drops only when
//           the queue is full, so non-stalling traffic never sees back-pressure.
//   Reset: synchronous, active low; clears the segment statistics, the queue,
//           the output register and sets min_duration_ns to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module trajectory_segment_classifier_core #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    tsc_in_if.sink                             i_in,
    tsc_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [tsc_pkg::MINDUR_W-1:0]  i_cfg_wdata
);
    import tsc_pkg::*;

    // snapshot layout: dur_ok, count, speed sum, range low, range high, low index
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int QW = 1 + CW + (CW + SPEED_W) + 2 * RANGE_W + PW;

    logic          push;
    logic          pop;
    logic [QW-1:0] push_entry;
    logic [QW-1:0] head_entry;
    t_q_status     q_stat;

    // front: running statistics and duration check, one beat per cycle while the queue is not full
    tsc_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // decouples the front from output stalls
    tsc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head_entry),
        .o_stat  (q_stat)
    );

    // back: thresholds, class priority, output register
    tsc_back #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

[rtl/core/tsc_checker.sv]
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the classifier core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trajectory_segment_classifier_core_defines.svh"

module tsc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_out_class
);

    // class beat stays offered until taken
    `TSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // stalled class beat keeps its value
    `TSC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_class))

    // input back-pressure only appears behind a stalled result
    `TSC_ASSERT_IMPL(a_bp_needs_result, i_clk, i_rst_n, !i_in_ready, i_out_valid)

    // reset empties the output
    `TSC_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind trajectory_segment_classifier_core tsc_checker u_tsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_class (o_out.segment_class)
);

`default_nettype wire
